// ===== hdl/pan_pkg.sv =====
// Shared types, constants and round functions of the Panama stream cipher core.
`default_nettype none
package pan_pkg;

  localparam int unsigned StageCount  = 32;
  localparam int unsigned WarmupPulls = 32;
  localparam int unsigned CoreWords   = 17;
  localparam int unsigned StageBits   = 256;
  localparam int unsigned StageAw     = $clog2(StageCount);
  localparam int unsigned RegCount    = 8;
  localparam int unsigned RegAw       = $clog2(RegCount);
  // Key push, vector push, warm-up pulls and the pull that yields the first block.
  localparam int unsigned InitRounds  = WarmupPulls + 3;
  localparam int unsigned RoundCw     = $clog2(InitRounds);
  localparam logic [31:0] RoundConst  = 32'h0000_0001;

  typedef logic [CoreWords-1:0][31:0] core_t;
  typedef logic [StageBits-1:0] stage_t;

  typedef enum logic {
    OP_CRYPT  = 1'b0,
    OP_REINIT = 1'b1
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [7:0] data;
  } item_t;

  typedef enum logic [2:0] {
    E_IDLE,
    E_CLEAR,
    E_RD1,
    E_RD2,
    E_WR1,
    E_WR2,
    E_EMIT
  } eng_state_e;

  function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] r);
    logic [63:0] w;
    begin
      w = {x, x} << r;
      return w[63:32];
    end
  endfunction

  // Gamma, pi and theta of one round, all word-parallel.
  function automatic core_t nonlinear_mix(input core_t s);
    core_t g;
    core_t p;
    core_t th;
    begin
      for (int i = 0; i < CoreWords; i++) begin
        g[i] = s[i] ^ (s[(i + 1) % CoreWords] | ~s[(i + 2) % CoreWords]);
      end
      p[0] = g[0];
      for (int i = 1; i < CoreWords; i++) begin
        p[i] = rotl32(g[(7 * i) % CoreWords], 5'((i * (i + 1)) >> 1));
      end
      for (int i = 0; i < CoreWords; i++) begin
        th[i] = p[i] ^ p[(i + 1) % CoreWords] ^ p[(i + 4) % CoreWords];
      end
      return th;
    end
  endfunction

endpackage
`default_nettype wire

// ===== hdl/pan_ram.sv =====
// Generic simple dual-read RAM with one write port and registered read data.
`default_nettype none
module pan_ram #(
  parameter int unsigned Width = 256,
  parameter int unsigned Depth = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_a_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_b_i,
  output logic      [Width-1:0]         rdata_a_o,
  output logic      [Width-1:0]         rdata_b_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule
`default_nettype wire

// ===== hdl/pan_front.sv =====
// Input side: accepts words, classifies them and queues them for the engine.
`default_nettype none
module pan_front #(
  parameter int unsigned Depth = 2
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire logic          func_i,
  input  wire logic [7:0]    data_byte_i,
  output logic               item_valid_o,
  output pan_pkg::item_t     item_o,
  input  wire logic          item_pop_i
);

  localparam int unsigned Aw = (Depth > 1) ? $clog2(Depth) : 1;

  pan_pkg::item_t     buf_q [Depth];
  logic [Aw-1:0]      wptr_q, wptr_d, rptr_q, rptr_d;
  logic [Aw:0]        cnt_q, cnt_d;
  logic               push;
  pan_pkg::item_t     item_in;

  assign in_ready_o   = (cnt_q != (Aw+1)'(Depth));
  assign item_valid_o = (cnt_q != '0);
  assign push         = in_valid_i && in_ready_o;
  assign item_o       = buf_q[rptr_q];

  always_comb begin
    item_in.op   = func_i ? pan_pkg::OP_REINIT : pan_pkg::OP_CRYPT;
    item_in.data = data_byte_i;
  end

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push) begin
      wptr_d = (wptr_q == Aw'(Depth - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (item_pop_i) begin
      rptr_d = (rptr_q == Aw'(Depth - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (push && !item_pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push && item_pop_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      buf_q[wptr_q] <= item_in;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/pan_engine.sv =====
// Back end: runs Panama rounds on the stage buffer RAM and produces result words.
`default_nettype none
module pan_engine (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          item_valid_i,
  input  wire pan_pkg::item_t item_i,
  output logic               item_pop_o,
  input  wire logic [255:0]  key_i,
  input  wire logic [255:0]  iv_i,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output logic [7:0]         result_byte_o
);

  localparam int unsigned Aw = pan_pkg::StageAw;

  pan_pkg::eng_state_e state_q, state_d;

  pan_pkg::core_t            core_q;
  pan_pkg::stage_t           block_q;
  pan_pkg::stage_t           s_high_q, s_low_q, b0_q;
  logic [pan_pkg::StageCount-1:0] valid_q;
  logic [Aw-1:0]             tap_q;
  logic [5:0]                pos_q;
  logic [pan_pkg::RoundCw-1:0] rnd_q;
  logic                      keyed_q, init_q;
  logic                      vld_a_q, vld_b_q;
  logic                      out_valid_q;
  logic [7:0]                result_q;

  logic [Aw-1:0]   t4, t16, t0, t25;
  logic            ram_we;
  logic [Aw-1:0]   ram_waddr, ram_ra, ram_rb;
  pan_pkg::stage_t ram_wdata, rd_a, rd_b, da, db;
  pan_pkg::stage_t inj, q_blk, s_low, b25_new;
  pan_pkg::core_t  th;
  logic            push_rnd, out_free, emit, needs_pull;
  logic [7:0]      ks_byte;

  assign t4  = tap_q + Aw'(4);
  assign t16 = tap_q + Aw'(16);
  assign t0  = tap_q - Aw'(1);
  assign t25 = tap_q + Aw'(24);

  assign da = vld_a_q ? rd_a : '0;
  assign db = vld_b_q ? rd_b : '0;

  assign push_rnd   = init_q && (rnd_q < pan_pkg::RoundCw'(2));
  assign inj        = (rnd_q == '0) ? key_i : iv_i;
  assign q_blk      = push_rnd ? inj : pan_pkg::stage_t'(core_q[8:1]);
  assign s_low      = push_rnd ? inj : s_low_q;
  assign b25_new    = db ^ {da[63:0], da[255:64]};
  assign th         = pan_pkg::nonlinear_mix(core_q);
  assign out_free   = !out_valid_q || out_ready_i;
  assign needs_pull = keyed_q && pos_q[5];
  assign ks_byte    = keyed_q ? block_q[{pos_q[4:0], 3'b000} +: 8] : 8'h00;

  pan_ram #(
    .Width (pan_pkg::StageBits),
    .Depth (pan_pkg::StageCount)
  ) u_stage_ram (
    .clk_i     (clk_i),
    .we_i      (ram_we),
    .waddr_i   (ram_waddr),
    .wdata_i   (ram_wdata),
    .raddr_a_i (ram_ra),
    .raddr_b_i (ram_rb),
    .rdata_a_o (rd_a),
    .rdata_b_o (rd_b)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      pan_pkg::E_IDLE: begin
        if (item_valid_i) begin
          if (item_i.op == pan_pkg::OP_REINIT) begin
            state_d = pan_pkg::E_CLEAR;
          end else if (needs_pull) begin
            state_d = pan_pkg::E_RD1;
          end else begin
            state_d = pan_pkg::E_EMIT;
          end
        end
      end
      pan_pkg::E_CLEAR: state_d = pan_pkg::E_RD1;
      pan_pkg::E_RD1:   state_d = pan_pkg::E_RD2;
      pan_pkg::E_RD2:   state_d = pan_pkg::E_WR1;
      pan_pkg::E_WR1:   state_d = pan_pkg::E_WR2;
      pan_pkg::E_WR2: begin
        if (!init_q) begin
          state_d = pan_pkg::E_EMIT;
        end else if (rnd_q == pan_pkg::RoundCw'(pan_pkg::InitRounds - 1)) begin
          state_d = pan_pkg::E_IDLE;
        end else begin
          state_d = pan_pkg::E_RD1;
        end
      end
      pan_pkg::E_EMIT: begin
        if (out_free) begin
          state_d = pan_pkg::E_IDLE;
        end
      end
      default: state_d = pan_pkg::E_IDLE;
    endcase
  end

  // Outputs of the sequencer: RAM port control, queue pop and result emission.
  always_comb begin
    ram_we     = 1'b0;
    ram_waddr  = t25;
    ram_wdata  = b25_new;
    ram_ra     = t16;
    ram_rb     = t4;
    item_pop_o = 1'b0;
    emit       = 1'b0;
    unique case (state_q)
      pan_pkg::E_IDLE: begin
        item_pop_o = item_valid_i && (item_i.op == pan_pkg::OP_REINIT);
      end
      pan_pkg::E_RD2: begin
        ram_ra = t0;
        ram_rb = t25;
      end
      pan_pkg::E_WR1: begin
        ram_we = 1'b1;
      end
      pan_pkg::E_WR2: begin
        ram_we    = 1'b1;
        ram_waddr = t0;
        ram_wdata = b0_q ^ q_blk;
      end
      pan_pkg::E_EMIT: begin
        emit       = out_free;
        item_pop_o = out_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pan_pkg::E_IDLE;
      core_q      <= '0;
      block_q     <= '0;
      s_high_q    <= '0;
      s_low_q     <= '0;
      b0_q        <= '0;
      valid_q     <= '0;
      tap_q       <= '0;
      pos_q       <= '0;
      rnd_q       <= '0;
      keyed_q     <= 1'b0;
      init_q      <= 1'b0;
      vld_a_q     <= 1'b0;
      vld_b_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (emit) begin
        out_valid_q <= 1'b1;
        pos_q       <= keyed_q ? pos_q + 6'd1 : pos_q;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        pan_pkg::E_IDLE: begin
          if (item_valid_i && item_i.op == pan_pkg::OP_CRYPT && needs_pull) begin
            block_q <= pan_pkg::stage_t'(core_q[16:9]);
            pos_q   <= '0;
            init_q  <= 1'b0;
          end
        end
        pan_pkg::E_CLEAR: begin
          core_q  <= '0;
          valid_q <= '0;
          tap_q   <= '0;
          rnd_q   <= '0;
          init_q  <= 1'b1;
        end
        pan_pkg::E_RD1: begin
          vld_a_q <= valid_q[t16];
          vld_b_q <= valid_q[t4];
          if (init_q && rnd_q == pan_pkg::RoundCw'(pan_pkg::InitRounds - 1)) begin
            block_q <= pan_pkg::stage_t'(core_q[16:9]);
          end
        end
        pan_pkg::E_RD2: begin
          s_high_q <= da;
          s_low_q  <= db;
          vld_a_q  <= valid_q[t0];
          vld_b_q  <= valid_q[t25];
        end
        pan_pkg::E_WR1: begin
          b0_q         <= da;
          valid_q[t25] <= 1'b1;
        end
        pan_pkg::E_WR2: begin
          valid_q[t0] <= 1'b1;
          tap_q       <= t0;
          core_q[0]   <= th[0] ^ pan_pkg::RoundConst;
          for (int i = 0; i < 8; i++) begin
            core_q[i+1] <= th[i+1] ^ s_low[32*i +: 32];
            core_q[i+9] <= th[i+9] ^ s_high_q[32*i +: 32];
          end
          if (init_q) begin
            rnd_q <= rnd_q + 1'b1;
            if (rnd_q == pan_pkg::RoundCw'(pan_pkg::InitRounds - 1)) begin
              keyed_q <= 1'b1;
              pos_q   <= '0;
              init_q  <= 1'b0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      result_q <= item_i.data ^ ks_byte;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign result_byte_o = result_q;

endmodule
`default_nettype wire

// ===== hdl/panama_stream_cipher_core.sv =====
// Top level of the Panama stream cipher core: configuration registers, queue and engine.
`default_nettype none
// Each data word XORs one byte with the next keystream byte; bytes sent before the
// first reinitialize pass through unchanged. A data word passes through the engine
// states idle and emit; every 32 bytes it first runs a pull round on the stage buffer RAM,
// whose single write port takes the writes in WR1 and WR2 and whose registered reads are issued in RD1 and RD2.
// A reinitialize word takes one clearing state and then 35 such rounds,
// and gives no result. Key and vector registers are read only at reinitialize.
module panama_stream_cipher_core #(
  parameter int unsigned QueueDepth = 2
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic        func_i,
  input  wire logic [7:0]  data_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [7:0]       result_byte_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [pan_pkg::RegAw-1:0] cfg_index_i,
  input  wire logic [63:0] cfg_data_i
);

  logic [pan_pkg::RegCount-1:0][63:0] regs_q;
  logic            item_valid, item_pop;
  pan_pkg::item_t  item;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      regs_q[cfg_index_i] <= cfg_data_i;
    end
  end

  pan_front #(
    .Depth (QueueDepth)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .func_i       (func_i),
    .data_byte_i  (data_byte_i),
    .item_valid_o (item_valid),
    .item_o       (item),
    .item_pop_i   (item_pop)
  );

  pan_engine u_engine (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .item_valid_i  (item_valid),
    .item_i        (item),
    .item_pop_o    (item_pop),
    .key_i         (regs_q[3:0]),
    .iv_i          (regs_q[7:4]),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .result_byte_o (result_byte_o)
  );

endmodule
`default_nettype wire

// ===== hdl/pan_checker.sv =====
// Port-level checker for the Panama stream cipher core, bound to the top level.
`default_nettype none
module pan_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       out_valid_o,
  input wire logic       out_ready_i,
  input wire logic [7:0] result_byte_o,
  input wire logic       cfg_ready_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result word dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(result_byte_o))
    else $error("result word changed while stalled");

  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready_o)
    else $error("configuration port not ready");

  a_reset_out: assert property (@(posedge clk_i)
    !rst_ni |-> !out_valid_o)
    else $error("result valid during reset");

endmodule

bind panama_stream_cipher_core pan_checker u_pan_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .result_byte_o (result_byte_o),
  .cfg_ready_o   (cfg_ready_o)
);
`default_nettype wire

// ===== verif/panama_stream_cipher_core_test.sv =====
// Self-checking testbench for the Panama stream cipher core: byte stream against a keystream predictor.
`default_nettype none
module panama_stream_cipher_core_test;

  localparam int unsigned ClkPeriod = 12;
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned ReinitWait = 400;

  typedef struct {
    pan_pkg::op_e op;
    logic [7:0]   data;
  } byte_word_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic func_i = 1'b0;
  logic [7:0] data_byte_i = 8'h00;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [7:0] result_byte_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [pan_pkg::RegAw-1:0] cfg_index_i = '0;
  logic [63:0] cfg_data_i = '0;

  panama_stream_cipher_core dut (.*);

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // Predictor state.
  logic [63:0] key_regs [pan_pkg::RegCount];
  logic [31:0] core_w [pan_pkg::CoreWords];
  logic [31:0] ring [pan_pkg::StageCount][8];
  logic [4:0] tap;
  logic [31:0] ks_block [8];
  logic [5:0] ks_pos;
  bit keyed;

  byte_word_t pending_words[$];
  logic [7:0] expected_bytes[$];
  int errors = 0;
  int cycles = 0;
  bit quiet = 1'b0;       // no random idling on either side
  bit hold_off = 1'b0;    // receiver holds off completely
  bit driving = 1'b0;

  function automatic logic [31:0] rot_word(logic [31:0] x, int n);
    n = n % 32;
    return n == 0 ? x : ((x << n) | (x >> (32 - n)));
  endfunction

  // One round; a push supplies its block, a pull passes has_inj = 0.
  task automatic cipher_round(bit has_inj, logic [31:0] inj [8]);
    logic [31:0] g [pan_pkg::CoreWords];
    logic [31:0] p [pan_pkg::CoreWords];
    logic [31:0] th [pan_pkg::CoreWords];
    logic [31:0] q [8];
    logic [31:0] lo [8];
    logic [31:0] hi [8];
    logic [4:0] t4, t16, t0, t25;
    for (int i = 0; i < pan_pkg::CoreWords; i++)
      g[i] = core_w[i] ^ (core_w[(i + 1) % pan_pkg::CoreWords] |
                          ~core_w[(i + 2) % pan_pkg::CoreWords]);
    p[0] = g[0];
    for (int i = 1; i < pan_pkg::CoreWords; i++)
      p[i] = rot_word(g[(7 * i) % pan_pkg::CoreWords], (i * (i + 1) / 2) % 32);
    for (int i = 0; i < pan_pkg::CoreWords; i++)
      th[i] = p[i] ^ p[(i + 1) % pan_pkg::CoreWords] ^ p[(i + 4) % pan_pkg::CoreWords];
    t4 = tap + 5'd4;
    t16 = tap + 5'd16;
    for (int i = 0; i < 8; i++) begin
      hi[i] = ring[t16][i];
      q[i] = has_inj ? inj[i] : core_w[i + 1];
      lo[i] = has_inj ? inj[i] : ring[t4][i];
    end
    tap = tap - 5'd1;
    t0 = tap;
    t25 = tap + 5'd25;
    for (int i = 0; i < 8; i++) ring[t25][i] ^= ring[t0][(i + 2) % 8];
    for (int i = 0; i < 8; i++) ring[t0][i] ^= q[i];
    core_w[0] = th[0] ^ pan_pkg::RoundConst;
    for (int i = 1; i <= 8; i++) core_w[i] = th[i] ^ lo[i - 1];
    for (int i = 9; i <= 16; i++) core_w[i] = th[i] ^ hi[i - 9];
  endtask

  task automatic pull_keystream();
    logic [31:0] none [8];
    for (int i = 0; i < 8; i++) ks_block[i] = core_w[9 + i];
    cipher_round(1'b0, none);
  endtask

  task automatic rekey();
    logic [31:0] w [8];
    for (int i = 0; i < pan_pkg::CoreWords; i++) core_w[i] = '0;
    for (int s = 0; s < pan_pkg::StageCount; s++) for (int i = 0; i < 8; i++) ring[s][i] = '0;
    tap = '0;
    for (int i = 0; i < 4; i++) begin
      w[2 * i] = key_regs[i][31:0];
      w[2 * i + 1] = key_regs[i][63:32];
    end
    cipher_round(1'b1, w);
    for (int i = 0; i < 4; i++) begin
      w[2 * i] = key_regs[4 + i][31:0];
      w[2 * i + 1] = key_regs[4 + i][63:32];
    end
    cipher_round(1'b1, w);
    for (int i = 0; i < pan_pkg::WarmupPulls; i++) cipher_round(1'b0, w);
    pull_keystream();
    ks_pos = '0;
    keyed = 1'b1;
  endtask

  task automatic predict_word(byte_word_t w);
    logic [7:0] ks;
    ks = 8'h00;
    if (w.op == pan_pkg::OP_REINIT) begin
      rekey();
      return;
    end
    if (keyed) begin
      if (ks_pos >= 32) begin
        pull_keystream();
        ks_pos = '0;
      end
      ks = 8'(ks_block[ks_pos[4:2]] >> (8 * ks_pos[1:0]));
      ks_pos = ks_pos + 6'd1;
    end
    expected_bytes.push_back(w.data ^ ks);
  endtask

  task automatic report(string what, logic [7:0] got, logic [7:0] want);
    $display("mismatch: %s got %02h expected %02h", what, got, want);
    errors++;
  endtask

  task automatic send_next();
    byte_word_t w;
    w = pending_words.pop_front();
    in_valid_i <= 1'b1;
    func_i <= w.op;
    data_byte_i <= w.data;
  endtask

  // Input acceptance is taken at the rising edge and acted on at the next falling edge.
  logic in_taken = 1'b0;
  always @(posedge clk_i) begin
    in_taken <= in_valid_i && in_ready_o;
  end

  // Driver: words leave the queue at the falling edge; the predictor runs on acceptance.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (in_taken) begin
        predict_word('{op: pan_pkg::op_e'(func_i), data: data_byte_i});
        if (pending_words.size() > 0 && (quiet || $urandom_range(99) >= 18))
          send_next();
        else
          in_valid_i <= 1'b0;
      end else if (!in_valid_i && pending_words.size() > 0 &&
                   (quiet || $urandom_range(99) >= 18)) begin
        send_next();
      end
      out_ready_i <= !hold_off && (quiet || $urandom_range(99) >= 18);
    end
  end

  // Monitor.
  always @(posedge clk_i) begin
    cycles++;
    if (out_valid_o && out_ready_i) begin
      if (expected_bytes.size() == 0) report("unexpected byte", result_byte_o, 8'h00);
      else begin
        logic [7:0] want;
        want = expected_bytes.pop_front();
        if (result_byte_o !== want) report("result_byte", result_byte_o, want);
      end
    end
    if (cycles > CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic write_reg(int idx, logic [63:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= pan_pkg::RegAw'(idx);
    cfg_data_i <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    key_regs[idx] = val;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic drain();
    while (pending_words.size() > 0 || in_valid_i || expected_bytes.size() > 0)
      @(posedge clk_i);
    // A reinitialize gives no result and may still be running.
    repeat (ReinitWait) @(posedge clk_i);
  endtask

  task automatic queue_word(pan_pkg::op_e op, logic [7:0] d);
    pending_words.push_back('{op: op, data: d});
  endtask

  task automatic queue_stream(int n);
    for (int i = 0; i < n; i++) queue_word(pan_pkg::OP_CRYPT, 8'($urandom));
  endtask

  initial begin
    for (int i = 0; i < pan_pkg::RegCount; i++) key_regs[i] = '0;
    for (int i = 0; i < pan_pkg::CoreWords; i++) core_w[i] = '0;
    for (int s = 0; s < pan_pkg::StageCount; s++) for (int i = 0; i < 8; i++) ring[s][i] = '0;
    for (int i = 0; i < 8; i++) ks_block[i] = '0;
    tap = '0;
    ks_pos = '0;
    keyed = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Bytes before any reinitialize pass through.
    queue_word(pan_pkg::OP_CRYPT, 8'h00);
    queue_word(pan_pkg::OP_CRYPT, 8'hFF);
    queue_word(pan_pkg::OP_CRYPT, 8'hA5);
    // Reinitialize with all-zero key, data bits ignored.
    queue_word(pan_pkg::OP_REINIT, 8'hFF);
    queue_stream(18);
    drain();

    // All-ones key and vector, crossing a block boundary.
    for (int i = 0; i < pan_pkg::RegCount; i++) write_reg(i, '1);
    queue_word(pan_pkg::OP_REINIT, 8'h00);
    queue_word(pan_pkg::OP_CRYPT, 8'hFF);
    queue_word(pan_pkg::OP_CRYPT, 8'h00);
    queue_stream(40);
    drain();

    // Register writes only take effect at the next reinitialize.
    for (int i = 0; i < pan_pkg::RegCount; i++) write_reg(i, {$urandom, $urandom});
    queue_stream(20);
    drain();

    // Receiver holds off while the sender keeps offering words.
    queue_word(pan_pkg::OP_REINIT, 8'h3C);
    queue_stream(60);
    hold_off = 1'b1;
    repeat (600) @(posedge clk_i);
    hold_off = 1'b0;
    drain();

    // Random phases with fresh keys; one stretch with no idling.
    for (int ph = 0; ph < 5; ph++) begin
      for (int i = 0; i < pan_pkg::RegCount; i++)
        if ($urandom_range(1)) write_reg(i, {$urandom, $urandom});
      quiet = (ph == 2);
      queue_word(pan_pkg::OP_REINIT, 8'($urandom));
      for (int i = 0; i < 90; i++) begin
        if ($urandom_range(99) < 2) queue_word(pan_pkg::OP_REINIT, 8'($urandom));
        else queue_word(pan_pkg::OP_CRYPT, 8'($urandom));
      end
      drain();
    end
    quiet = 1'b0;

    if (errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end
endmodule
`default_nettype wire
